@@ src/rgb_to_hue_sat_value_top_assert.svh @@
// assertion macros for the rgb to hue/saturation/value block
`ifndef RGB_TO_HUE_SAT_VALUE_TOP_ASSERT_SVH
`define RGB_TO_HUE_SAT_VALUE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RHSV_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("rhsv assertion failed");
`define RHSV_CHECK(lbl, prop) `RHSV_ASSERT(lbl, clk, rst, prop)
`else
`define RHSV_ASSERT(lbl, clk_s, rst_s, prop)
`define RHSV_CHECK(lbl, prop)
`endif
`endif

@@ src/rhsv_pkg.sv @@
// types, constants and angle table for the rgb to hue/saturation/value block
package rhsv_pkg;

  localparam int CordicSteps = 28;
  localparam int DivSteps    = 17;
  localparam logic [16:0] Sqrt3Q16 = 17'd113512;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_in;
  } pixel_t;

  typedef struct packed {
    logic [15:0] hue;
    logic [15:0] saturation;
    logic [15:0] brightness;
    logic        last_out;
  } result_t;

  // data carried from cell to cell
  typedef struct packed {
    logic signed [28:0] x;
    logic signed [28:0] y;
    logic signed [33:0] acc;
    logic [24:0]        rem;
    logic [8:0]         den;
    logic [16:0]        quo;
    logic [15:0]        val;
    logic               chroma;
    logic               dz;
    logic               xpos;
    logic               mirror;
    logic               last;
  } stage_t;

  // cordic step angles in units of 2^-32 turn
  function automatic logic [31:0] step_angle(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

@@ src/rhsv_cell.sv @@
// one cell: a cordic vectoring step and, in the first DivSteps cells, a restoring divide step
module rhsv_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic [4:0]      step,
  input  logic            go,
  input  logic            in_valid,
  input  rhsv_pkg::stage_t in_data,
  output logic            out_valid,
  output rhsv_pkg::stage_t out_data
);
  import rhsv_pkg::*;

  stage_t             data_next;
  logic signed [28:0] dx;
  logic signed [28:0] dy;
  logic [4:0]         qbit;
  logic [24:0]        dsh;

  // shift toward zero
  function automatic logic signed [28:0] shr_tz(input logic signed [28:0] v,
                                                input logic [4:0] s);
    logic signed [28:0] r;
    if (v[28]) begin
      r = -((-v) >>> s);
    end else begin
      r = v >>> s;
    end
    return r;
  endfunction

  always_comb begin
    data_next = in_data;
    dx = shr_tz(in_data.y, step);
    dy = shr_tz(in_data.x, step);
    // rotate toward the x axis
    if (!in_data.y[28]) begin
      data_next.x   = in_data.x + dx;
      data_next.y   = in_data.y - dy;
      data_next.acc = in_data.acc + $signed({2'b00, step_angle(step)});
    end else begin
      data_next.x   = in_data.x - dx;
      data_next.y   = in_data.y + dy;
      data_next.acc = in_data.acc - $signed({2'b00, step_angle(step)});
    end
    // quotient bit, high bits in the early cells
    qbit = 5'(DivSteps - 1) - step;
    dsh  = {16'd0, in_data.den} << qbit;
    if (step < 5'(DivSteps) && in_data.rem >= dsh) begin
      data_next.rem = in_data.rem - dsh;
      data_next.quo = in_data.quo | (17'd1 << qbit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= in_valid;
    end
    if (go) begin
      out_data <= data_next;
    end
  end

endmodule

@@ src/rgb_to_hue_sat_value_top.sv @@
// top level of the rgb to hue/saturation/value converter
// Takes one pixel per clock and returns hue, saturation and brightness as
// 16-bit fractions by way of one input register, a row of 28 cells that
// each do one cordic step for the hue angle and (in the first 17) one bit of
// the saturation divide, and one output register. Pixels stream back to back
// at one per cycle; a stall at the output stops only the stages that are full,
// so empty slots in the row close up before the input is stalled.
module rgb_to_hue_sat_value_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              pixel_valid,
  output logic              pixel_stall,
  input  rhsv_pkg::pixel_t  pixel,
  output logic              result_valid,
  input  logic              result_stall,
  output rhsv_pkg::result_t result
);
  import rhsv_pkg::*;
  `include "rgb_to_hue_sat_value_top_assert.svh"

  logic        front_valid;
  stage_t      front;
  stage_t      front_next;
  logic        go_front;
  logic        go_out;
  logic [CordicSteps-1:0] cv;
  logic [CordicSteps:0]   go;
  stage_t      cd [CordicSteps];

  logic [7:0]  mx;
  logic [7:0]  mn;
  logic [16:0] val17;
  logic signed [9:0]  x10;
  logic signed [28:0] xs;
  logic [7:0]  ad;
  logic [24:0] y25;

  logic signed [33:0] acc;
  logic [31:0] ang;
  logic [32:0] ang33;
  logic [16:0] h17;
  logic [15:0] hue_calc;
  logic [15:0] sat_calc;
  stage_t      last_cell;

  // stage advance chain, slots close up under stall
  assign go_out              = !result_valid || !result_stall;
  assign go[CordicSteps]     = go_out;
  assign go_front            = !front_valid || go[0];
  assign pixel_stall         = !go_front;

  // input stage: max, min, brightness and start vectors
  always_comb begin
    mx = pixel.red;
    mn = pixel.red;
    if (pixel.green > mx) mx = pixel.green;
    if (pixel.blue > mx) mx = pixel.blue;
    if (pixel.green < mn) mn = pixel.green;
    if (pixel.blue < mn) mn = pixel.blue;
    val17 = {1'b0, mx, 8'd0} + {9'd0, mx} + {16'd0, mx[7]};
    x10 = $signed({1'b0, pixel.red, 1'b0}) - $signed({2'b00, pixel.green})
          - $signed({2'b00, pixel.blue});
    xs = {{3{x10[9]}}, x10, 16'd0};
    ad = (pixel.green >= pixel.blue) ? pixel.green - pixel.blue
                                     : pixel.blue - pixel.green;
    y25 = ad * Sqrt3Q16;
    front_next.val    = val17[16] ? 16'hFFFF : val17[15:0];
    front_next.chroma = (mx != 8'd0) && (mx != mn);
    front_next.dz     = pixel.green == pixel.blue;
    front_next.xpos   = !x10[9] && (x10 != 10'sd0);
    front_next.mirror = pixel.blue > pixel.green;
    front_next.last   = pixel.last_in;
    front_next.rem    = {mx - mn, 17'd0} + {17'd0, mx};
    front_next.den    = {mx, 1'b0};
    front_next.quo    = '0;
    // left half plane: turn by a quarter and preload it
    if (x10[9]) begin
      front_next.x   = {4'd0, y25};
      front_next.y   = -xs;
      front_next.acc = 34'sd1 <<< 30;
    end else begin
      front_next.x   = xs;
      front_next.y   = {4'd0, y25};
      front_next.acc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (go_front) begin
      front_valid <= pixel_valid;
    end
    if (go_front) begin
      front <= front_next;
    end
  end

  // row of cells
  for (genvar k = 0; k < CordicSteps; k++) begin : g_cell
    if (k == 0) begin : g_first
      rhsv_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .step     (5'(k)),
        .go       (go[k]),
        .in_valid (front_valid),
        .in_data  (front),
        .out_valid(cv[k]),
        .out_data (cd[k])
      );
    end else begin : g_rest
      rhsv_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .step     (5'(k)),
        .go       (go[k]),
        .in_valid (cv[k-1]),
        .in_data  (cd[k-1]),
        .out_valid(cv[k]),
        .out_data (cd[k])
      );
    end
    assign go[k] = !cv[k] || go[k+1];
  end

  // output stage: clamp, mirror, round
  always_comb begin
    last_cell = cd[CordicSteps-1];
    acc = last_cell.acc;
    if (last_cell.dz) begin
      ang = last_cell.xpos ? 32'd0 : 32'h80000000;
    end else if (acc[33]) begin
      ang = 32'd0;
    end else if (acc > 34'sh080000000) begin
      ang = 32'h80000000;
    end else begin
      ang = acc[31:0];
    end
    if (last_cell.mirror) begin
      ang33 = 33'h100000000 - {1'b0, ang};
    end else begin
      ang33 = {1'b0, ang};
    end
    h17 = 17'((ang33 + 33'h8000) >> 16);
    hue_calc = !last_cell.chroma ? 16'd0 : (h17[16] ? 16'hFFFF : h17[15:0]);
    sat_calc = !last_cell.chroma ? 16'd0 :
               (last_cell.quo[16] ? 16'hFFFF : last_cell.quo[15:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (go_out) begin
      result_valid <= cv[CordicSteps-1];
    end
    if (go_out) begin
      result.hue        <= hue_calc;
      result.saturation <= sat_calc;
      result.brightness <= last_cell.val;
      result.last_out   <= last_cell.last;
    end
  end

  // gray pixels leave the input stage with no chroma
  `RHSV_CHECK(a_gray_no_chroma, pixel_valid && !pixel_stall && pixel.red == pixel.green && pixel.green == pixel.blue |=> !front.chroma)
  // unmirrored hue stays within half a turn
  `RHSV_CHECK(a_hue_half, cv[CordicSteps-1] && !last_cell.mirror |-> hue_calc <= 16'd32768)
  // a held last cell keeps its transaction
  `RHSV_CHECK(a_last_hold, cv[CordicSteps-1] && !go_out |=> cv[CordicSteps-1])

endmodule

@@ bench/rgb_to_hue_sat_value_top_tb.sv @@
// testbench for the rgb to hue/saturation/value converter
module rgb_to_hue_sat_value_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rhsv_pkg::*;

  localparam int Latency = 30;
  localparam int WatchdogLimit = 5000;
  localparam int RandomPixels = 630;
  localparam int HoldOffCycles = 150;

  // hue cordic angle table, 2^-32 turn units
  localparam logic [31:0] HueStepAngle [28] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005};

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
    logic       known;
    result_t    res;
  } stim_row_t;

  logic    clk;
  logic    rst;
  logic    pixel_valid;
  logic    pixel_stall;
  pixel_t  pixel;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  result_t   pending_results[$];
  stim_row_t stim_rows[$];
  int        errors;
  int        sent;
  int        received;
  int        idle_cycles;
  bit        sending_done;
  bit        quiet_stretch;

  rgb_to_hue_sat_value_top dut (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint shift_toward_zero(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v) >>> s);
  endfunction

  function automatic logic [15:0] round_frac(longint unsigned num, longint unsigned den);
    longint unsigned q;
    q = (2 * num + den) / (2 * den);
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  // expected hue, saturation and brightness of one pixel
  function automatic result_t hsv_of_pixel(pixel_t p);
    result_t r;
    longint red, green, blue, mx, mn, x, y, acc, dx, dy, t, d;
    longint unsigned ang, h;
    red = p.red; green = p.green; blue = p.blue;
    mx = red; mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    r.hue = '0;
    r.saturation = '0;
    r.brightness = round_frac(mx << 16, 255);
    r.last_out = p.last_in;
    if (mx != 0 && mx != mn) begin
      x = 2 * red - green - blue;
      d = green - blue;
      r.saturation = round_frac((mx - mn) << 16, mx);
      if (d == 0) begin
        ang = (x > 0) ? 0 : (64'd1 << 31);
      end else begin
        x = x * 65536;
        y = (d < 0 ? -d : d) * 113512;
        acc = 0;
        if (x < 0) begin
          t = x; x = y; y = -t;
          acc = 64'd1 << 30;
        end
        for (int i = 0; i < 28; i++) begin
          dx = shift_toward_zero(y, i);
          dy = shift_toward_zero(x, i);
          if (y >= 0) begin
            x += dx; y -= dy; acc += HueStepAngle[i];
          end else begin
            x -= dx; y += dy; acc -= HueStepAngle[i];
          end
        end
        if (acc < 0) acc = 0;
        if (acc > (64'sd1 <<< 31)) acc = 64'sd1 <<< 31;
        ang = acc;
      end
      if (blue > green) ang = (64'd1 << 32) - ang;
      h = (ang + (64'd1 << 15)) >> 16;
      r.hue = (h > 65535) ? 16'hFFFF : h[15:0];
    end
    return r;
  endfunction

  function automatic stim_row_t row(int rd, int gr, int bl, bit lst, bit known = 0,
                                    int h = 0, int s = 0, int v = 0);
    stim_row_t sr;
    sr.red = 8'(rd); sr.green = 8'(gr); sr.blue = 8'(bl);
    sr.last = lst; sr.known = known;
    sr.res = '{hue: 16'(h), saturation: 16'(s), brightness: 16'(v), last_out: lst};
    return sr;
  endfunction

  // directed rows, then random pixels biased toward equal channels and edge values
  initial begin
    stim_row_t sr;
    stim_rows.push_back(row(0, 0, 0, 0, 1, 0, 0, 0));
    stim_rows.push_back(row(255, 255, 255, 1, 1, 0, 0, 65535));
    stim_rows.push_back(row(128, 128, 128, 0, 1, 0, 0, 32897));
    stim_rows.push_back(row(255, 0, 0, 0, 1, 0, 65535, 65535));
    stim_rows.push_back(row(0, 255, 255, 0, 1, 32768, 65535, 65535));
    stim_rows.push_back(row(1, 0, 0, 1, 1, 0, 65535, 257));
    stim_rows.push_back(row(0, 1, 1, 0, 1, 32768, 65535, 257));
    stim_rows.push_back(row(200, 100, 100, 0));
    stim_rows.push_back(row(0, 255, 0, 0));
    stim_rows.push_back(row(0, 0, 255, 0));
    stim_rows.push_back(row(255, 255, 0, 0));
    stim_rows.push_back(row(255, 0, 255, 1));
    stim_rows.push_back(row(254, 1, 0, 0));
    stim_rows.push_back(row(254, 0, 1, 0));
    stim_rows.push_back(row(0, 254, 255, 0));
    stim_rows.push_back(row(0, 255, 254, 0));
    stim_rows.push_back(row(170, 85, 255, 0));
    stim_rows.push_back(row(85, 170, 0, 0));
    stim_rows.push_back(row(255, 254, 254, 0));
    stim_rows.push_back(row(1, 2, 3, 1));
    for (int i = 0; i < RandomPixels; i++) begin
      sr = row($urandom_range(255), $urandom_range(255), $urandom_range(255),
               1'($urandom_range(1)));
      case ($urandom_range(7))
        0: sr.green = sr.blue;
        1: sr.red = sr.green;
        2: begin sr.green = sr.red; sr.blue = sr.red; end
        3: sr.red = $urandom_range(1) ? 8'd255 : 8'd0;
        default: ;
      endcase
      stim_rows.push_back(sr);
    end
  end

  // pixel sender
  initial begin
    stim_row_t sr;
    pixel_t p;
    rst <= 1'b1;
    pixel_valid <= 1'b0;
    pixel <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (stim_rows[k]) begin
      sr = stim_rows[k];
      p = '{red: sr.red, green: sr.green, blue: sr.blue, last_in: sr.last};
      while (!quiet_stretch && k > 20 && $urandom_range(99) < 35) begin
        pixel_valid <= 1'b0;
        @(posedge clk);
      end
      pixel_valid <= 1'b1;
      pixel <= p;
      pending_results.push_back(sr.known ? sr.res : hsv_of_pixel(p));
      if (sr.known && sr.res != hsv_of_pixel(p)) begin
        $error("predictor disagrees with table row %0d", k);
        errors++;
      end
      @(posedge clk);
      while (pixel_stall) @(posedge clk);
      sent++;
    end
    pixel_valid <= 1'b0;
    sending_done = 1'b1;
  end

  // result receiver with random stalls, a long hold-off and a no-stall stretch
  initial begin
    result_stall <= 1'b1;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (sent == 40) begin
        result_stall <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk);
      end
      quiet_stretch = (sent >= 300 && sent < 400);
      result_stall <= quiet_stretch ? 1'b0 : ($urandom_range(99) < 35);
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      received++;
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (result.hue !== want.hue) begin
          $error("hue: expected %0d, got %0d", want.hue, result.hue); errors++;
        end
        if (result.saturation !== want.saturation) begin
          $error("saturation: expected %0d, got %0d", want.saturation, result.saturation);
          errors++;
        end
        if (result.brightness !== want.brightness) begin
          $error("brightness: expected %0d, got %0d", want.brightness, result.brightness);
          errors++;
        end
        if (result.last_out !== want.last_out) begin
          $error("last_out: expected %0d, got %0d", want.last_out, result.last_out);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (sending_done);
    fork
      begin
        wait (pending_results.size() == 0);
        repeat (Latency + 10) @(posedge clk);
      end
      wait (idle_cycles >= WatchdogLimit);
    join_any
    if (pending_results.size() != 0) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("** rgb_to_hue_sat_value_top: FAILED **");
      $finish;
    end else begin
      $display("converted %0d pixels (directed edges, gray, g=b, random), %0d results",
               sent, received);
      if (errors == 0)
        $display("** rgb_to_hue_sat_value_top: PASSED **");
      else
        $display("** rgb_to_hue_sat_value_top: FAILED **");
      $finish;
    end
  end

  initial begin
    wait (idle_cycles >= WatchdogLimit);
    if (!sending_done) begin
      $display("timeout while sending pixels");
      $display("** rgb_to_hue_sat_value_top: FAILED **");
      $finish;
    end
  end

endmodule

@@ rgb_to_hue_sat_value_top.f @@
+incdir+src
src/rhsv_pkg.sv
src/rhsv_cell.sv
src/rgb_to_hue_sat_value_top.sv
bench/rgb_to_hue_sat_value_top_tb.sv
